FILE: design/ddwrm_pkg.sv
// shared types and constants for the differential drive wheel rate mixer
// no dependencies; used by every module of the block
`default_nettype none

package ddwrm_pkg;

   localparam int SPEED_W       = 32;  // linear and turn speed width
   localparam int LIMIT_W       = 31;  // drive and velocity limit width
   localparam int FACTOR_W      = 32;  // q16.16 conversion factors
   localparam int FACTOR_FRAC_W = 16;  // fraction bits of the factors
   localparam int SPEED_FRAC_W  = 8;   // fraction bits of physical speeds
   localparam int RATE_SHIFT    = SPEED_FRAC_W + FACTOR_FRAC_W;
   localparam int CSR_INDEX_W   = 2;
   localparam int CSR_DATA_W    = 32;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_DRIVE_LIMIT    = 2'd0,
      CSR_VELOCITY_LIMIT = 2'd1,
      CSR_STEPS_PER_MM   = 2'd2,
      CSR_MM_PER_DEGREE  = 2'd3
   } csr_index_type;

   typedef enum logic {
      OP_DRIVE    = 1'b0,
      OP_VELOCITY = 1'b1
   } opcode_type;

   typedef struct packed {
      logic [LIMIT_W-1:0]  drive_limit;
      logic [LIMIT_W-1:0]  velocity_limit;
      logic [FACTOR_W-1:0] steps_per_mm;
      logic [FACTOR_W-1:0] mm_per_degree;
   } cfg_type;

   localparam cfg_type CFG_RST = '{
      drive_limit:    31'd10000,
      velocity_limit: 31'd100000,
      steps_per_mm:   32'd65536,
      mm_per_degree:  32'd65536
   };

endpackage

`default_nettype wire

FILE: design/ddwrm_mix.sv
// kinematics front end: wheel speeds, unit conversion, saturation, limit check
// six register stages; depends on ddwrm_pkg
`default_nettype none

module ddwrm_mix #(
   parameter int RATE_WIDTH = 32
) (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire ddwrm_pkg::cfg_type              cfg,
   input  wire logic                            in_valid,
   output logic                                 in_ready,
   input  wire logic                            in_opcode,
   input  wire logic signed [ddwrm_pkg::SPEED_W-1:0] in_linear,
   input  wire logic signed [ddwrm_pkg::SPEED_W-1:0] in_turn,
   output logic                                 out_valid,
   input  wire logic                            out_ready,
   output logic                                 out_left_neg,
   output logic                                 out_right_neg,
   output logic [RATE_WIDTH-1:0]                out_left_mag,
   output logic [RATE_WIDTH-1:0]                out_right_mag,
   output logic [RATE_WIDTH-1:0]                out_divisor,
   output logic [ddwrm_pkg::LIMIT_W-1:0]        out_limit,
   output logic                                 out_limited
);

   localparam int SW      = ddwrm_pkg::SPEED_W;
   localparam int LW      = ddwrm_pkg::LIMIT_W;
   localparam int FW      = ddwrm_pkg::FACTOR_W;
   localparam int TPROD_W = SW + FW;
   localparam int TMM_W   = TPROD_W - ddwrm_pkg::FACTOR_FRAC_W;
   localparam int MM_W    = TMM_W + 2;
   localparam int HI_W    = MM_W - SW;
   localparam int HIP_W   = HI_W + FW;
   localparam int LOP_W   = SW + FW;
   localparam int HI_SH   = SW - ddwrm_pkg::RATE_SHIFT;
   localparam int Q_W     = HIP_W + HI_SH + 1;
   localparam int CMP_W   = (RATE_WIDTH > LW) ? RATE_WIDTH : LW;
   localparam int NSTG    = 6;

   localparam logic signed [SW:0] ONE_WIDE  = 1;
   localparam logic signed [SW:0] RMAX_WIDE = (ONE_WIDE <<< (RATE_WIDTH - 1)) - ONE_WIDE;
   localparam logic signed [SW:0] RMIN_WIDE = -RMAX_WIDE - ONE_WIDE;
   localparam logic [RATE_WIDTH-1:0] CAP_NEG = {1'b1, {(RATE_WIDTH - 1){1'b0}}};
   localparam logic [RATE_WIDTH-1:0] CAP_POS = {1'b0, {(RATE_WIDTH - 1){1'b1}}};

   function automatic logic signed [RATE_WIDTH-1:0] sat_rate(input logic signed [SW:0] v);
      logic signed [SW:0] c;
      if (v > RMAX_WIDE) begin
         c = RMAX_WIDE;
      end else if (v < RMIN_WIDE) begin
         c = RMIN_WIDE;
      end else begin
         c = v;
      end
      return c[RATE_WIDTH-1:0];
   endfunction

   // stage handshake
   logic [NSTG-1:0] valid_ff, valid_in, stage_en;

   // stage a: step mode sums, turn times mm_per_degree
   ddwrm_pkg::opcode_type        a_op_ff, a_op_in;
   logic signed [SW-1:0]         a_lin_ff;
   logic                         a_turn_neg_ff, a_turn_neg_in;
   logic [TPROD_W-1:0]           a_tprod_ff, a_tprod_in;
   logic signed [RATE_WIDTH-1:0] a_s0l_ff, a_s0l_in, a_s0r_ff, a_s0r_in;
   logic [SW-1:0]                a_tmag;
   logic signed [SW:0]           a_diff, a_sum;

   // stage b: wheel travel in q.8 mm/s
   ddwrm_pkg::opcode_type        b_op_ff;
   logic signed [MM_W-1:0]       b_mml_ff, b_mml_in, b_mmr_ff, b_mmr_in;
   logic signed [RATE_WIDTH-1:0] b_s0l_ff, b_s0r_ff;
   logic signed [MM_W-1:0]       b_lin, b_tmm;

   // stage c: sign and magnitude
   ddwrm_pkg::opcode_type        c_op_ff;
   logic                         c_negl_ff, c_negl_in, c_negr_ff, c_negr_in;
   logic [MM_W-1:0]              c_mml_ff, c_mml_in, c_mmr_ff, c_mmr_in;
   logic [RATE_WIDTH-1:0]        c_s0ml_ff, c_s0ml_in, c_s0mr_ff, c_s0mr_in;

   // stage d: partial products with steps_per_mm
   ddwrm_pkg::opcode_type        d_op_ff;
   logic                         d_negl_ff, d_negr_ff;
   logic [HIP_W-1:0]             d_hipl_ff, d_hipl_in, d_hipr_ff, d_hipr_in;
   logic [LOP_W-1:0]             d_lopl_ff, d_lopl_in, d_lopr_ff, d_lopr_in;
   logic [RATE_WIDTH-1:0]        d_s0ml_ff, d_s0mr_ff;

   // stage e: rate magnitude, clamped
   logic                         e_negl_ff, e_negr_ff;
   logic [RATE_WIDTH-1:0]        e_magl_ff, e_magl_in, e_magr_ff, e_magr_in;
   logic [LW-1:0]                e_limit_ff, e_limit_in;
   logic [Q_W-1:0]               e_ql, e_qr;
   logic [RATE_WIDTH-1:0]        e_capl, e_capr, e_physl, e_physr;

   // stage f: larger magnitude and limit compare
   logic                         f_negl_ff, f_negr_ff, f_limited_ff, f_limited_in;
   logic [RATE_WIDTH-1:0]        f_magl_ff, f_magr_ff, f_big_ff, f_big_in;
   logic [LW-1:0]                f_limit_ff;

   // bubbles collapse: a stage loads when empty or when the next one loads
   always_comb begin
      stage_en[NSTG-1] = !valid_ff[NSTG-1] || out_ready;
      for (int k = NSTG - 2; k >= 0; k--) begin
         stage_en[k] = !valid_ff[k] || stage_en[k+1];
      end
      valid_in[0] = stage_en[0] ? in_valid : valid_ff[0];
      for (int k = 1; k < NSTG; k++) begin
         valid_in[k] = stage_en[k] ? valid_ff[k-1] : valid_ff[k];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   assign in_ready = stage_en[0];

   // stage a
   always_comb begin
      a_op_in       = ddwrm_pkg::opcode_type'(in_opcode);
      a_turn_neg_in = in_turn[SW-1];
      a_tmag        = in_turn[SW-1] ? unsigned'(-in_turn) : unsigned'(in_turn);
      a_tprod_in    = TPROD_W'(a_tmag) * TPROD_W'(cfg.mm_per_degree);
      a_diff        = (SW + 1)'(in_linear) - (SW + 1)'(in_turn);
      a_sum         = (SW + 1)'(in_linear) + (SW + 1)'(in_turn);
      a_s0l_in      = sat_rate(a_diff);
      a_s0r_in      = sat_rate(a_sum);
   end

   always_ff @(posedge clock) begin
      if (stage_en[0]) begin
         a_op_ff       <= a_op_in;
         a_lin_ff      <= in_linear;
         a_turn_neg_ff <= a_turn_neg_in;
         a_tprod_ff    <= a_tprod_in;
         a_s0l_ff      <= a_s0l_in;
         a_s0r_ff      <= a_s0r_in;
      end
   end

   // stage b: the turn sign only swaps which wheel adds
   always_comb begin
      b_lin = MM_W'(a_lin_ff);
      b_tmm = signed'(MM_W'(a_tprod_ff[TPROD_W-1 -: TMM_W]));
      if (a_turn_neg_ff) begin
         b_mml_in = b_lin + b_tmm;
         b_mmr_in = b_lin - b_tmm;
      end else begin
         b_mml_in = b_lin - b_tmm;
         b_mmr_in = b_lin + b_tmm;
      end
   end

   always_ff @(posedge clock) begin
      if (stage_en[1]) begin
         b_op_ff  <= a_op_ff;
         b_mml_ff <= b_mml_in;
         b_mmr_ff <= b_mmr_in;
         b_s0l_ff <= a_s0l_ff;
         b_s0r_ff <= a_s0r_ff;
      end
   end

   // stage c
   always_comb begin
      c_mml_in  = b_mml_ff[MM_W-1] ? unsigned'(-b_mml_ff) : unsigned'(b_mml_ff);
      c_mmr_in  = b_mmr_ff[MM_W-1] ? unsigned'(-b_mmr_ff) : unsigned'(b_mmr_ff);
      c_s0ml_in = b_s0l_ff[RATE_WIDTH-1] ? unsigned'(-b_s0l_ff) : unsigned'(b_s0l_ff);
      c_s0mr_in = b_s0r_ff[RATE_WIDTH-1] ? unsigned'(-b_s0r_ff) : unsigned'(b_s0r_ff);
      if (b_op_ff == ddwrm_pkg::OP_VELOCITY) begin
         c_negl_in = b_mml_ff[MM_W-1];
         c_negr_in = b_mmr_ff[MM_W-1];
      end else begin
         c_negl_in = b_s0l_ff[RATE_WIDTH-1];
         c_negr_in = b_s0r_ff[RATE_WIDTH-1];
      end
   end

   always_ff @(posedge clock) begin
      if (stage_en[2]) begin
         c_op_ff   <= b_op_ff;
         c_negl_ff <= c_negl_in;
         c_negr_ff <= c_negr_in;
         c_mml_ff  <= c_mml_in;
         c_mmr_ff  <= c_mmr_in;
         c_s0ml_ff <= c_s0ml_in;
         c_s0mr_ff <= c_s0mr_in;
      end
   end

   // stage d: magnitude split at bit 32 keeps each product within 32 by 32
   always_comb begin
      d_hipl_in = HIP_W'(c_mml_ff[MM_W-1 -: HI_W]) * HIP_W'(cfg.steps_per_mm);
      d_hipr_in = HIP_W'(c_mmr_ff[MM_W-1 -: HI_W]) * HIP_W'(cfg.steps_per_mm);
      d_lopl_in = LOP_W'(c_mml_ff[SW-1:0]) * LOP_W'(cfg.steps_per_mm);
      d_lopr_in = LOP_W'(c_mmr_ff[SW-1:0]) * LOP_W'(cfg.steps_per_mm);
   end

   always_ff @(posedge clock) begin
      if (stage_en[3]) begin
         d_op_ff   <= c_op_ff;
         d_negl_ff <= c_negl_ff;
         d_negr_ff <= c_negr_ff;
         d_hipl_ff <= d_hipl_in;
         d_hipr_ff <= d_hipr_in;
         d_lopl_ff <= d_lopl_in;
         d_lopr_ff <= d_lopr_in;
         d_s0ml_ff <= c_s0ml_ff;
         d_s0mr_ff <= c_s0mr_ff;
      end
   end

   // stage e: negative side may reach one step further than positive
   always_comb begin
      e_ql    = (Q_W'(d_hipl_ff) << HI_SH) + Q_W'(d_lopl_ff[LOP_W-1:ddwrm_pkg::RATE_SHIFT]);
      e_qr    = (Q_W'(d_hipr_ff) << HI_SH) + Q_W'(d_lopr_ff[LOP_W-1:ddwrm_pkg::RATE_SHIFT]);
      e_capl  = d_negl_ff ? CAP_NEG : CAP_POS;
      e_capr  = d_negr_ff ? CAP_NEG : CAP_POS;
      e_physl = (e_ql > Q_W'(e_capl)) ? e_capl : e_ql[RATE_WIDTH-1:0];
      e_physr = (e_qr > Q_W'(e_capr)) ? e_capr : e_qr[RATE_WIDTH-1:0];
      if (d_op_ff == ddwrm_pkg::OP_VELOCITY) begin
         e_magl_in  = e_physl;
         e_magr_in  = e_physr;
         e_limit_in = cfg.velocity_limit;
      end else begin
         e_magl_in  = d_s0ml_ff;
         e_magr_in  = d_s0mr_ff;
         e_limit_in = cfg.drive_limit;
      end
   end

   always_ff @(posedge clock) begin
      if (stage_en[4]) begin
         e_negl_ff  <= d_negl_ff;
         e_negr_ff  <= d_negr_ff;
         e_magl_ff  <= e_magl_in;
         e_magr_ff  <= e_magr_in;
         e_limit_ff <= e_limit_in;
      end
   end

   // stage f
   always_comb begin
      f_big_in     = (e_magl_ff > e_magr_ff) ? e_magl_ff : e_magr_ff;
      f_limited_in = CMP_W'(f_big_in) > CMP_W'(e_limit_ff);
   end

   always_ff @(posedge clock) begin
      if (stage_en[5]) begin
         f_negl_ff    <= e_negl_ff;
         f_negr_ff    <= e_negr_ff;
         f_magl_ff    <= e_magl_ff;
         f_magr_ff    <= e_magr_ff;
         f_big_ff     <= f_big_in;
         f_limit_ff   <= e_limit_ff;
         f_limited_ff <= f_limited_in;
      end
   end

   assign out_valid     = valid_ff[NSTG-1];
   assign out_left_neg  = f_negl_ff;
   assign out_right_neg = f_negr_ff;
   assign out_left_mag  = f_magl_ff;
   assign out_right_mag = f_magr_ff;
   assign out_divisor   = f_big_ff;
   assign out_limit     = f_limit_ff;
   assign out_limited   = f_limited_ff;

endmodule

`default_nettype wire

FILE: design/ddwrm_div.sv
// proportional limiter: magnitude times limit, then a restoring divider
// one quotient bit per stage for both wheels; depends on ddwrm_pkg
`default_nettype none

module ddwrm_div #(
   parameter int RATE_WIDTH = 32
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          in_valid,
   output logic                               in_ready,
   input  wire logic                          in_left_neg,
   input  wire logic                          in_right_neg,
   input  wire logic [RATE_WIDTH-1:0]         in_left_mag,
   input  wire logic [RATE_WIDTH-1:0]         in_right_mag,
   input  wire logic [RATE_WIDTH-1:0]         in_divisor,
   input  wire logic [ddwrm_pkg::LIMIT_W-1:0] in_limit,
   input  wire logic                          in_limited,
   output logic                               out_valid,
   input  wire logic                          out_ready,
   output logic                               out_left_neg,
   output logic                               out_right_neg,
   output logic [RATE_WIDTH-1:0]              out_left_mag,
   output logic [RATE_WIDTH-1:0]              out_right_mag,
   output logic [RATE_WIDTH-2:0]              out_left_quo,
   output logic [RATE_WIDTH-2:0]              out_right_quo,
   output logic                               out_limited
);

   localparam int QW   = RATE_WIDTH - 1;
   localparam int LW   = ddwrm_pkg::LIMIT_W;
   localparam int PW   = RATE_WIDTH + LW;
   localparam int NSTG = QW + 1;

   typedef struct packed {
      logic [RATE_WIDTH-1:0] rem_l;
      logic [RATE_WIDTH-1:0] rem_r;
      logic [QW-1:0]         low_l;
      logic [QW-1:0]         low_r;
      logic [QW-1:0]         quo_l;
      logic [QW-1:0]         quo_r;
      logic [RATE_WIDTH-1:0] divisor;
      logic [RATE_WIDTH-1:0] mag_l;
      logic [RATE_WIDTH-1:0] mag_r;
      logic                  neg_l;
      logic                  neg_r;
      logic                  limited;
   } div_stage_type;

   function automatic div_stage_type div_step(input div_stage_type s);
      div_stage_type     n;
      logic [RATE_WIDTH:0] tl, tr, dv;
      n  = s;
      dv = {1'b0, s.divisor};
      tl = {s.rem_l, s.low_l[QW-1]};
      tr = {s.rem_r, s.low_r[QW-1]};
      if (tl >= dv) begin
         n.rem_l = RATE_WIDTH'(tl - dv);
         n.quo_l = {s.quo_l[QW-2:0], 1'b1};
      end else begin
         n.rem_l = tl[RATE_WIDTH-1:0];
         n.quo_l = {s.quo_l[QW-2:0], 1'b0};
      end
      if (tr >= dv) begin
         n.rem_r = RATE_WIDTH'(tr - dv);
         n.quo_r = {s.quo_r[QW-2:0], 1'b1};
      end else begin
         n.rem_r = tr[RATE_WIDTH-1:0];
         n.quo_r = {s.quo_r[QW-2:0], 1'b0};
      end
      n.low_l = s.low_l << 1;
      n.low_r = s.low_r << 1;
      return n;
   endfunction

   logic [NSTG-1:0] valid_ff, valid_in, stage_en;

   // product stage
   logic [PW-1:0]         g_prodl_ff, g_prodl_in, g_prodr_ff, g_prodr_in;
   logic [RATE_WIDTH-1:0] g_div_ff, g_magl_ff, g_magr_ff;
   logic                  g_negl_ff, g_negr_ff, g_limited_ff;

   div_stage_type st_init;
   div_stage_type st_ff [1:QW];
   div_stage_type st_in [1:QW];

   always_comb begin
      stage_en[NSTG-1] = !valid_ff[NSTG-1] || out_ready;
      for (int k = NSTG - 2; k >= 0; k--) begin
         stage_en[k] = !valid_ff[k] || stage_en[k+1];
      end
      valid_in[0] = stage_en[0] ? in_valid : valid_ff[0];
      for (int k = 1; k < NSTG; k++) begin
         valid_in[k] = stage_en[k] ? valid_ff[k-1] : valid_ff[k];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   assign in_ready = stage_en[0];

   always_comb begin
      g_prodl_in = PW'(in_left_mag) * PW'(in_limit);
      g_prodr_in = PW'(in_right_mag) * PW'(in_limit);
   end

   always_ff @(posedge clock) begin
      if (stage_en[0]) begin
         g_prodl_ff   <= g_prodl_in;
         g_prodr_ff   <= g_prodr_in;
         g_div_ff     <= in_divisor;
         g_magl_ff    <= in_left_mag;
         g_magr_ff    <= in_right_mag;
         g_negl_ff    <= in_left_neg;
         g_negr_ff    <= in_right_neg;
         g_limited_ff <= in_limited;
      end
   end

   // quotient fits qw bits, so the top of the dividend is already below the divisor
   always_comb begin
      st_init.rem_l   = g_prodl_ff[QW +: RATE_WIDTH];
      st_init.rem_r   = g_prodr_ff[QW +: RATE_WIDTH];
      st_init.low_l   = g_prodl_ff[QW-1:0];
      st_init.low_r   = g_prodr_ff[QW-1:0];
      st_init.quo_l   = '0;
      st_init.quo_r   = '0;
      st_init.divisor = g_div_ff;
      st_init.mag_l   = g_magl_ff;
      st_init.mag_r   = g_magr_ff;
      st_init.neg_l   = g_negl_ff;
      st_init.neg_r   = g_negr_ff;
      st_init.limited = g_limited_ff;
   end

   always_comb begin
      st_in[1] = div_step(st_init);
      for (int k = 2; k <= QW; k++) begin
         st_in[k] = div_step(st_ff[k-1]);
      end
   end

   always_ff @(posedge clock) begin
      for (int k = 1; k <= QW; k++) begin
         if (stage_en[k]) begin
            st_ff[k] <= st_in[k];
         end
      end
   end

   assign out_valid     = valid_ff[NSTG-1];
   assign out_left_neg  = st_ff[QW].neg_l;
   assign out_right_neg = st_ff[QW].neg_r;
   assign out_left_mag  = st_ff[QW].mag_l;
   assign out_right_mag = st_ff[QW].mag_r;
   assign out_left_quo  = st_ff[QW].quo_l;
   assign out_right_quo = st_ff[QW].quo_r;
   assign out_limited   = st_ff[QW].limited;

`ifndef SYNTHESIS
   // the divisor is the larger magnitude and cannot be zero when limiting
   a_divisor_is_max: assert property (@(posedge clock) disable iff (reset)
      valid_ff[0] && g_limited_ff |->
         (g_div_ff != '0) && ((g_magl_ff == g_div_ff) || (g_magr_ff == g_div_ff)))
      else $error("limited request with a divisor that is not the larger magnitude");

   // scaling never increases a wheel rate
   a_quo_not_above_mag: assert property (@(posedge clock) disable iff (reset)
      out_valid && out_limited |->
         (RATE_WIDTH'(out_left_quo) <= out_left_mag) &&
         (RATE_WIDTH'(out_right_quo) <= out_right_mag))
      else $error("scaled rate larger than the unscaled rate");

   // remainder left after the last step stays below the divisor
   a_rem_below_div: assert property (@(posedge clock) disable iff (reset)
      out_valid && out_limited |->
         (st_ff[QW].rem_l < st_ff[QW].divisor) && (st_ff[QW].rem_r < st_ff[QW].divisor))
      else $error("divider remainder not below divisor");
`endif

endmodule

`default_nettype wire

FILE: design/diff_drive_wheel_rate_mixer.sv
// throughput: one request per cycle while results are taken; the limiter divider
// retires one quotient bit per stage, so its RATE_WIDTH - 1 stages set the depth
// but not the rate
// idle stages collapse, so requests keep entering while a result waits
// reset: synchronous, active high; clears the valid bits and loads register defaults
// top level; instantiates ddwrm_mix and ddwrm_div, depends on ddwrm_pkg
`default_nettype none

module diff_drive_wheel_rate_mixer #(
   parameter int RATE_WIDTH = 32
) (
   input  wire logic                              clock,
   input  wire logic                              reset,
   // request channel
   input  wire logic                              req_tvalid,
   output logic                                   req_tready,
   input  wire logic [2*ddwrm_pkg::SPEED_W-1:0]   req_tdata,  // linear_speed, turn_speed
   input  wire logic [0:0]                        req_tuser,  // opcode
   // result channel
   output logic                                   rsp_tvalid,
   input  wire logic                              rsp_tready,
   output logic [2*ddwrm_pkg::SPEED_W-1:0]        rsp_tdata,  // left_rate, right_rate
   output logic [0:0]                             rsp_tuser,  // was_limited
   // register writes
   input  wire logic                              csr_we,
   input  wire logic [ddwrm_pkg::CSR_INDEX_W-1:0] csr_index,
   input  wire logic [ddwrm_pkg::CSR_DATA_W-1:0]  csr_wdata
);

   localparam int SW = ddwrm_pkg::SPEED_W;
   localparam int LW = ddwrm_pkg::LIMIT_W;
   localparam int FW = ddwrm_pkg::FACTOR_W;

   // configuration registers
   ddwrm_pkg::cfg_type cfg_ff, cfg_in;

   // mixer to limiter
   logic                  mix_valid, mix_ready;
   logic                  mix_negl, mix_negr, mix_limited;
   logic [RATE_WIDTH-1:0] mix_magl, mix_magr, mix_div;
   logic [LW-1:0]         mix_limit;

   // limiter to output register
   logic                  div_valid, div_ready;
   logic                  div_negl, div_negr, div_limited;
   logic [RATE_WIDTH-1:0] div_magl, div_magr;
   logic [RATE_WIDTH-2:0] div_quol, div_quor;

   // output register
   logic                         rsp_valid_ff, rsp_limited_ff;
   logic [SW-1:0]                rsp_left_ff, rsp_left_in, rsp_right_ff, rsp_right_in;
   logic [RATE_WIDTH-1:0]        val_l, val_r;
   logic signed [RATE_WIDTH-1:0] rate_l, rate_r;

   // writes are masked to each register's width
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         case (ddwrm_pkg::csr_index_type'(csr_index))
            ddwrm_pkg::CSR_DRIVE_LIMIT:    cfg_in.drive_limit    = csr_wdata[LW-1:0];
            ddwrm_pkg::CSR_VELOCITY_LIMIT: cfg_in.velocity_limit = csr_wdata[LW-1:0];
            ddwrm_pkg::CSR_STEPS_PER_MM:   cfg_in.steps_per_mm   = csr_wdata[FW-1:0];
            ddwrm_pkg::CSR_MM_PER_DEGREE:  cfg_in.mm_per_degree  = csr_wdata[FW-1:0];
            default: cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= ddwrm_pkg::CFG_RST;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // wheel speeds, unit conversion, saturation and the limit check
   ddwrm_mix #(
      .RATE_WIDTH (RATE_WIDTH)
   ) u_mix (
      .clock         (clock),
      .reset         (reset),
      .cfg           (cfg_ff),
      .in_valid      (req_tvalid),
      .in_ready      (req_tready),
      .in_opcode     (req_tuser[0]),
      .in_linear     (signed'(req_tdata[SW-1:0])),
      .in_turn       (signed'(req_tdata[2*SW-1:SW])),
      .out_valid     (mix_valid),
      .out_ready     (mix_ready),
      .out_left_neg  (mix_negl),
      .out_right_neg (mix_negr),
      .out_left_mag  (mix_magl),
      .out_right_mag (mix_magr),
      .out_divisor   (mix_div),
      .out_limit     (mix_limit),
      .out_limited   (mix_limited)
   );

   // both wheels scaled by limit over the larger magnitude
   ddwrm_div #(
      .RATE_WIDTH (RATE_WIDTH)
   ) u_div (
      .clock         (clock),
      .reset         (reset),
      .in_valid      (mix_valid),
      .in_ready      (mix_ready),
      .in_left_neg   (mix_negl),
      .in_right_neg  (mix_negr),
      .in_left_mag   (mix_magl),
      .in_right_mag  (mix_magr),
      .in_divisor    (mix_div),
      .in_limit      (mix_limit),
      .in_limited    (mix_limited),
      .out_valid     (div_valid),
      .out_ready     (div_ready),
      .out_left_neg  (div_negl),
      .out_right_neg (div_negr),
      .out_left_mag  (div_magl),
      .out_right_mag (div_magr),
      .out_left_quo  (div_quol),
      .out_right_quo (div_quor),
      .out_limited   (div_limited)
   );

   // output register loads whenever it is empty or being drained
   assign div_ready = !rsp_valid_ff || rsp_tready;

   // pick scaled or unscaled magnitude, restore the sign, widen to the port
   always_comb begin
      val_l        = div_limited ? {1'b0, div_quol} : div_magl;
      val_r        = div_limited ? {1'b0, div_quor} : div_magr;
      rate_l       = div_negl ? signed'(-val_l) : signed'(val_l);
      rate_r       = div_negr ? signed'(-val_r) : signed'(val_r);
      rsp_left_in  = SW'(rate_l);
      rsp_right_in = SW'(rate_r);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (div_ready) begin
         rsp_valid_ff <= div_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (div_ready) begin
         rsp_left_ff    <= rsp_left_in;
         rsp_right_ff   <= rsp_right_in;
         rsp_limited_ff <= div_limited;
      end
   end

   assign rsp_tvalid   = rsp_valid_ff;
   assign rsp_tdata    = {rsp_right_ff, rsp_left_ff};
   assign rsp_tuser[0] = rsp_limited_ff;

endmodule

`default_nettype wire

FILE: sim/tb.sv
// testbench for diff_drive_wheel_rate_mixer: mixes drive and velocity requests and
// checks each left/right wheel rate and limit flag against an in-bench predictor
// depends on ddwrm_pkg and the rtl of the block
`timescale 1ns / 1ps

module tb;

   localparam int SPEED_W       = ddwrm_pkg::SPEED_W;
   localparam int LIMIT_W       = ddwrm_pkg::LIMIT_W;
   localparam int CSR_DATA_W    = ddwrm_pkg::CSR_DATA_W;
   localparam int RATE_SHIFT    = ddwrm_pkg::RATE_SHIFT;
   localparam int FACTOR_FRAC_W = ddwrm_pkg::FACTOR_FRAC_W;

   // request to result depth at the default rate width
   localparam int RESULT_LATENCY = 39;
   localparam int TIMEOUT_NS     = 5_000_000;

   localparam longint RATE_MAX = 64'sd2147483647;
   localparam longint RATE_MIN = -64'sd2147483648;
   localparam logic signed [SPEED_W-1:0] SPEED_MAX = 32'sh7fff_ffff;
   localparam logic signed [SPEED_W-1:0] SPEED_MIN = 32'sh8000_0000;

   // one predicted result of the mixer
   typedef struct {
      logic signed [SPEED_W-1:0] left_rate;
      logic signed [SPEED_W-1:0] right_rate;
      logic                      limited;
   } wheel_rates_type;

   logic                     clock      = 1'b0;
   logic                     reset      = 1'b1;
   logic                     req_tvalid = 1'b0;
   logic                     req_tready;
   logic [2*SPEED_W-1:0]     req_tdata  = '0;  // linear_speed, turn_speed
   logic [0:0]               req_tuser  = '0;  // opcode
   logic                     rsp_tvalid;
   logic                     rsp_tready = 1'b0;
   logic [2*SPEED_W-1:0]     rsp_tdata;        // left_rate, right_rate
   logic [0:0]               rsp_tuser;        // was_limited
   logic                     csr_we     = 1'b0;
   ddwrm_pkg::csr_index_type csr_index  = ddwrm_pkg::CSR_DRIVE_LIMIT;
   logic [CSR_DATA_W-1:0]    csr_wdata  = '0;

   // bench copy of the register file, tracks every write
   ddwrm_pkg::cfg_type wheel_cfg = ddwrm_pkg::CFG_RST;
   // predicted results in request order
   wheel_rates_type    expected_rates[$];
   wheel_rates_type    expected_now;
   int                 failures      = 0;
   // idle and stall odds in percent, changed per traffic phase
   int                 req_idle_pct  = 0;
   int                 rsp_stall_pct = 0;

   always #5 clock = ~clock;

   diff_drive_wheel_rate_mixer DUT (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   // ---------------------------------------------------------------- predictor

   function automatic longint clamp_rate(longint v);
      if (v > RATE_MAX) return RATE_MAX;
      if (v < RATE_MIN) return RATE_MIN;
      return v;
   endfunction

   // q.8 mm/s times q16.16 steps/mm, truncated toward zero, then saturated
   function automatic longint mm_to_steps(longint mm);
      logic [127:0] q;
      longint       m;
      m = (mm < 0) ? -mm : mm;
      q = (128'(m) * 128'(wheel_cfg.steps_per_mm)) >> RATE_SHIFT;
      if (mm < 0)
         return (q > 128'h8000_0000) ? RATE_MIN : -longint'(q[63:0]);
      return (q > 128'h7fff_ffff) ? RATE_MAX : longint'(q[63:0]);
   endfunction

   function automatic wheel_rates_type mix_wheel_rates(ddwrm_pkg::opcode_type op,
                                                      logic signed [SPEED_W-1:0] lin,
                                                      logic signed [SPEED_W-1:0] turn);
      wheel_rates_type res;
      longint          left, right, lim, big, turn_mm;
      logic [63:0]     turn_abs;
      if (op == ddwrm_pkg::OP_DRIVE) begin
         // step mode: plain sum and difference, saturated instead of wrapped
         left  = clamp_rate(longint'(lin) - longint'(turn));
         right = clamp_rate(longint'(lin) + longint'(turn));
         lim   = longint'(wheel_cfg.drive_limit);
      end else begin
         // physical mode: turn in deg/s becomes wheel travel in mm/s first
         turn_abs = (turn < 0) ? -longint'(turn) : longint'(turn);
         turn_mm  = longint'((turn_abs * 64'(wheel_cfg.mm_per_degree)) >> FACTOR_FRAC_W);
         if (turn < 0) turn_mm = -turn_mm;
         left  = mm_to_steps(longint'(lin) - turn_mm);
         right = mm_to_steps(longint'(lin) + turn_mm);
         lim   = longint'(wheel_cfg.velocity_limit);
      end
      // proportional limit on the larger wheel magnitude
      big = (left < 0) ? -left : left;
      if (((right < 0) ? -right : right) > big) big = (right < 0) ? -right : right;
      res.limited = (big > lim);
      if (res.limited) begin
         left  = left * lim / big;
         right = right * lim / big;
      end
      res.left_rate  = left[SPEED_W-1:0];
      res.right_rate = right[SPEED_W-1:0];
      return res;
   endfunction

   // ---------------------------------------------------------------- drivers

   // one request; valid stays high on return so back-to-back requests need no gap
   task automatic send_request(ddwrm_pkg::opcode_type op, logic signed [SPEED_W-1:0] lin,
                               logic signed [SPEED_W-1:0] turn);
      while ($urandom_range(99) < req_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {turn, lin};
      req_tuser  <= op;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      expected_rates.push_back(mix_wheel_rates(op, lin, turn));
   endtask

   // drop valid and let every pending result come out
   task automatic wait_for_results();
      req_tvalid <= 1'b0;
      while (expected_rates.size() != 0) @(posedge clock);
   endtask

   // writes all four registers; only called with the pipeline empty
   task automatic load_registers(logic [31:0] drive, logic [31:0] velocity,
                                 logic [31:0] steps, logic [31:0] travel);
      logic [31:0] values [4];
      values = '{drive, velocity, steps, travel};
      for (int i = 0; i < 4; i++) begin
         csr_we    <= 1'b1;
         csr_index <= ddwrm_pkg::csr_index_type'(i);
         csr_wdata <= values[i];
         @(posedge clock);
         // limits keep only their low 31 bits
         case (ddwrm_pkg::csr_index_type'(i))
            ddwrm_pkg::CSR_DRIVE_LIMIT:
               wheel_cfg.drive_limit    = values[i][LIMIT_W-1:0];
            ddwrm_pkg::CSR_VELOCITY_LIMIT:
               wheel_cfg.velocity_limit = values[i][LIMIT_W-1:0];
            ddwrm_pkg::CSR_STEPS_PER_MM:
               wheel_cfg.steps_per_mm   = values[i];
            ddwrm_pkg::CSR_MM_PER_DEGREE:
               wheel_cfg.mm_per_degree  = values[i];
            default: ;
         endcase
      end
      csr_we <= 1'b0;
   endtask

   // ---------------------------------------------------------------- random values

   // mix of full range, smaller magnitudes, and extremes
   function automatic logic signed [SPEED_W-1:0] random_speed();
      logic signed [SPEED_W-1:0] v;
      case ($urandom_range(5))
         0, 1: return $urandom;
         2: v = $urandom_range(300);
         3: v = $urandom_range(30000);
         4: v = $urandom_range(3000000);
         default: return $urandom_range(1) ? SPEED_MAX : SPEED_MIN;
      endcase
      return $urandom_range(1) ? -v : v;
   endfunction

   function automatic logic [31:0] random_limit();
      case ($urandom_range(3))
         0: return $urandom;
         1: return $urandom_range(300000);
         2: return $urandom_range(100000000);
         default: return $urandom_range(1) ? 32'hffff_ffff : 32'h0;
      endcase
   endfunction

   function automatic logic [31:0] random_factor();
      case ($urandom_range(3))
         0: return $urandom;
         1: return $urandom_range(32'h0100_0000, 32'h1000);
         2: return 32'h0001_0000 + $urandom_range(4096);
         default: return $urandom_range(1) ? 32'hffff_ffff : 32'h0;
      endcase
   endfunction

   // ---------------------------------------------------------------- tests

   // register values right after reset, both modes
   task automatic test_reset_defaults();
      req_idle_pct  = 0;
      rsp_stall_pct = 0;
      send_request(ddwrm_pkg::OP_DRIVE, 0, 0);
      send_request(ddwrm_pkg::OP_DRIVE, 5000, 3000);            // under the limit
      send_request(ddwrm_pkg::OP_DRIVE, 9000, 2000);            // right wheel over the limit
      send_request(ddwrm_pkg::OP_DRIVE, SPEED_MAX, SPEED_MAX);  // sum saturates high
      send_request(ddwrm_pkg::OP_DRIVE, SPEED_MIN, SPEED_MAX);  // difference saturates low
      send_request(ddwrm_pkg::OP_DRIVE, SPEED_MIN, SPEED_MIN);
      send_request(ddwrm_pkg::OP_VELOCITY, 0, 0);
      send_request(ddwrm_pkg::OP_VELOCITY, 32'sd25600, 32'sd2560); // 100 mm/s, 10 deg/s
      send_request(ddwrm_pkg::OP_VELOCITY, -1, 1);
      send_request(ddwrm_pkg::OP_VELOCITY, SPEED_MAX, SPEED_MIN);
      send_request(ddwrm_pkg::OP_VELOCITY, SPEED_MIN, SPEED_MAX);
      wait_for_results();
   endtask

   // a zero limit forces any nonzero request to zero and sets the flag
   task automatic test_zero_limits();
      load_registers(32'h0, 32'h0, 32'h0001_0000, 32'h0001_0000);
      send_request(ddwrm_pkg::OP_DRIVE, 0, 0);
      send_request(ddwrm_pkg::OP_DRIVE, 1, 0);
      send_request(ddwrm_pkg::OP_DRIVE, -7, 3);
      send_request(ddwrm_pkg::OP_VELOCITY, 256, 0);
      send_request(ddwrm_pkg::OP_VELOCITY, 0, 0);
      wait_for_results();
   endtask

   // largest limits and factors, then zero factors with a tiny limit
   task automatic test_extreme_settings();
      load_registers(32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff);
      send_request(ddwrm_pkg::OP_DRIVE, SPEED_MAX, SPEED_MIN);
      send_request(ddwrm_pkg::OP_VELOCITY, SPEED_MAX, SPEED_MAX);
      send_request(ddwrm_pkg::OP_VELOCITY, SPEED_MIN, -1);
      send_request(ddwrm_pkg::OP_VELOCITY, 1, 0);
      wait_for_results();
      // top bit of a limit write is dropped, so the drive limit becomes 1
      load_registers(32'h8000_0001, 32'h1, 32'h0, 32'h0);
      send_request(ddwrm_pkg::OP_VELOCITY, SPEED_MAX, SPEED_MIN);
      send_request(ddwrm_pkg::OP_DRIVE, 3, -1);
      send_request(ddwrm_pkg::OP_VELOCITY, SPEED_MIN, SPEED_MAX);
      wait_for_results();
   endtask

   // random requests under one idle/stall mix, two register settings per phase
   task automatic test_random_traffic(int idle_pct, int stall_pct, int items);
      req_idle_pct  = idle_pct;
      rsp_stall_pct = stall_pct;
      for (int half = 0; half < 2; half++) begin
         load_registers(random_limit(), random_limit(), random_factor(), random_factor());
         for (int n = 0; n < items / 2; n++)
            send_request(ddwrm_pkg::opcode_type'($urandom_range(1)), random_speed(),
                         random_speed());
         wait_for_results();
      end
   endtask

   // ---------------------------------------------------------------- checking

   task automatic report_failure(string what);
      failures++;
      if (failures <= 10) $display("[%0t] mismatch: %s", $time, what);
   endtask

   // receiver: random backpressure and in-order compare of every result
   always @(posedge clock) begin
      rsp_tready <= ($urandom_range(99) >= rsp_stall_pct);
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (expected_rates.size() == 0) begin
            report_failure($sformatf("unexpected result left %0d right %0d limited %0b",
                                     $signed(rsp_tdata[31:0]), $signed(rsp_tdata[63:32]),
                                     rsp_tuser[0]));
         end else begin
            expected_now = expected_rates.pop_front();
            if (rsp_tdata[31:0] !== expected_now.left_rate ||
                rsp_tdata[63:32] !== expected_now.right_rate ||
                rsp_tuser[0] !== expected_now.limited) begin
               report_failure($sformatf(
                  "expected left %0d right %0d limited %0b, got left %0d right %0d limited %0b",
                  expected_now.left_rate, expected_now.right_rate, expected_now.limited,
                  $signed(rsp_tdata[31:0]), $signed(rsp_tdata[63:32]), rsp_tuser[0]));
            end
         end
      end
   end

   // ---------------------------------------------------------------- sequence

   initial begin
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      test_reset_defaults();
      test_zero_limits();
      test_extreme_settings();
      test_random_traffic(0, 0, 150);     // full rate both sides
      test_random_traffic(78, 0, 150);    // sparse requests
      test_random_traffic(0, 78, 150);    // heavy backpressure
      test_random_traffic(17, 17, 150);   // light gaps on both sides
      // give any stray result time to show up
      repeat (RESULT_LATENCY + 10) @(posedge clock);
      if (failures == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end

   // hang guard
   initial begin
      #(TIMEOUT_NS);
      $display("CHECKS FAILED");
      $finish;
   end

endmodule
